>>> design/csv_three_count_line_parser_macros.svh
// Assertion macros used by the line parser top level.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef CSV_THREE_COUNT_LINE_PARSER_MACROS_SVH
`define CSV_THREE_COUNT_LINE_PARSER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSV3LP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CSV3LP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/csv3lp_pkg.sv
// Types, character codes and helper functions for the three-count line parser.
// Depends on nothing; imported by csv3lp_parse and the top level.
`timescale 1ns / 1ps

package csv3lp_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int unsigned VAL_W = 16;
  localparam int unsigned ACC_W = VAL_W + 1;
  // Saturation point of the digit accumulator: one above the largest legal value.
  localparam logic [ACC_W-1:0] ACC_SAT = {1'b1, {VAL_W{1'b0}}};

  typedef enum logic [1:0] {
    PH_LEAD  = 2'd0,
    PH_SIGN  = 2'd1,
    PH_DIGIT = 2'd2,
    PH_TRAIL = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_ACCEPT   = 2'd1,
    EV_REJECT   = 2'd2,
    EV_OVERFLOW = 2'd3
  } event_t;

  // Parse state of the line being collected (length is kept apart, its width varies).
  typedef struct packed {
    logic [1:0]       field_index;
    phase_t           phase;
    logic             minus_seen;
    logic [ACC_W-1:0] acc;
    logic             line_error;
    logic             nul_seen;
    logic [VAL_W-1:0] pending_first;
    logic [VAL_W-1:0] pending_second;
  } line_st_t;

  // Snapshot of the last accepted line plus the bad-line counter.
  typedef struct packed {
    logic [VAL_W-1:0] person;
    logic [VAL_W-1:0] half;
    logic [VAL_W-1:0] work;
    logic [31:0]      tick;
    logic [31:0]      bad_count;
  } snap_t;

  localparam line_st_t LINE_CLEAR = '{
    field_index:    2'd0,
    phase:          PH_LEAD,
    minus_seen:     1'b0,
    acc:            '0,
    line_error:     1'b0,
    nul_seen:       1'b0,
    pending_first:  '0,
    pending_second: '0
  };

  localparam snap_t SNAP_CLEAR = '{
    person:    '0,
    half:      '0,
    work:      '0,
    tick:      '0,
    bad_count: '0
  };

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VT) || (b == CH_FF);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  // A field cannot be used: dangling sign, value too large, or a nonzero negative.
  function automatic logic field_bad(input line_st_t s);
    return (s.phase == PH_SIGN) || s.acc[ACC_W-1] ||
           (s.minus_seen && (s.acc != '0));
  endfunction

endpackage

>>> design/csv3lp_parse.sv
// Next-state logic of the line parser: classifies one byte and updates the state.
// Depends on csv3lp_pkg.
`timescale 1ns / 1ps

module csv3lp_parse
  import csv3lp_pkg::*;
#(
  parameter int unsigned LINE_BYTES = 32,
  parameter int unsigned LEN_W      = $clog2(LINE_BYTES)
) (
  input  logic [7:0]       rx_byte,
  input  logic [31:0]      now_tick,
  input  line_st_t         cur_line,
  input  logic [LEN_W-1:0] cur_len,
  input  snap_t            cur_snap,
  output line_st_t         nxt_line,
  output logic [LEN_W-1:0] nxt_len,
  output snap_t            nxt_snap,
  output event_t           nxt_event
);

  localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_BYTES - 1);

  logic             is_term;
  logic             line_bad;
  logic [ACC_W+3:0] acc_mul;

  assign is_term  = (rx_byte == CH_LF) || (rx_byte == CH_CR);
  assign line_bad = cur_line.line_error || field_bad(cur_line) ||
                    (cur_line.field_index != 2'd2);
  // acc * 10 + digit, done as two shifts and adds.
  assign acc_mul  = ({4'd0, cur_line.acc} << 3) + ({4'd0, cur_line.acc} << 1) +
                    (ACC_W + 4)'(rx_byte[3:0]);

  always_comb begin
    nxt_line  = cur_line;
    nxt_len   = cur_len;
    nxt_snap  = cur_snap;
    nxt_event = EV_NONE;

    if (is_term) begin
      if (cur_len != '0) begin
        if (!line_bad) begin
          nxt_snap.person = cur_line.pending_first;
          nxt_snap.half   = cur_line.pending_second;
          nxt_snap.work   = cur_line.acc[VAL_W-1:0];
          nxt_snap.tick   = now_tick;
          nxt_event       = EV_ACCEPT;
        end else begin
          nxt_snap.bad_count = cur_snap.bad_count + 32'd1;
          nxt_event          = EV_REJECT;
        end
        nxt_line = LINE_CLEAR;
        nxt_len  = '0;
      end
    end else if (cur_len >= LEN_LAST) begin
      nxt_snap.bad_count = cur_snap.bad_count + 32'd1;
      nxt_event          = EV_OVERFLOW;
      nxt_line           = LINE_CLEAR;
      nxt_len            = '0;
    end else begin
      if (!cur_line.nul_seen) begin
        if (rx_byte == CH_NUL) begin
          // A line that opens with NUL has no text at all and is rejected.
          if (cur_len == '0) begin
            nxt_line.line_error = 1'b1;
          end
          nxt_line.nul_seen = 1'b1;
        end else if (!cur_line.line_error) begin
          if (is_blank(rx_byte)) begin
            if (cur_line.phase == PH_SIGN) begin
              nxt_line.line_error = 1'b1;
            end else if (cur_line.phase == PH_DIGIT) begin
              nxt_line.phase = PH_TRAIL;
            end
          end else if ((rx_byte == CH_PLUS) || (rx_byte == CH_MINUS)) begin
            if (cur_line.phase == PH_LEAD) begin
              nxt_line.phase      = PH_SIGN;
              nxt_line.minus_seen = (rx_byte == CH_MINUS);
            end else begin
              nxt_line.line_error = 1'b1;
            end
          end else if (is_digit(rx_byte)) begin
            if (cur_line.phase == PH_TRAIL) begin
              nxt_line.line_error = 1'b1;
            end else begin
              nxt_line.phase = PH_DIGIT;
              if (acc_mul > (ACC_W + 4)'(ACC_SAT)) begin
                nxt_line.acc = ACC_SAT;
              end else begin
                nxt_line.acc = acc_mul[ACC_W-1:0];
              end
            end
          end else if (rx_byte == CH_COMMA) begin
            if (field_bad(cur_line) || (cur_line.field_index >= 2'd2)) begin
              nxt_line.line_error = 1'b1;
            end else begin
              if (cur_line.field_index == 2'd0) begin
                nxt_line.pending_first = cur_line.acc[VAL_W-1:0];
              end else begin
                nxt_line.pending_second = cur_line.acc[VAL_W-1:0];
              end
              nxt_line.field_index = cur_line.field_index + 2'd1;
            end
            nxt_line.phase      = PH_LEAD;
            nxt_line.minus_seen = 1'b0;
            nxt_line.acc        = '0;
          end else begin
            nxt_line.line_error = 1'b1;
          end
        end
      end
      nxt_len = cur_len + LEN_W'(1);
    end
  end

endmodule

>>> design/csv_three_count_line_parser.sv
// Top level of the three-count line parser: stream ports, input register, state
// and result registers. Depends on csv3lp_pkg, csv3lp_parse and the macros header.
//
//  Channel | Direction | tdata (low bit first)                     | tuser
//  --------+-----------+-------------------------------------------+------------
//  in_     | slave     | rx_byte[7:0], now_tick[39:8]              | none
//  out_    | master    | person, half, work, commit_tick,          | line_event
//          |           | bad_line_count (16,16,16,32,32 bits)      |
//
// Every input transaction yields exactly one output transaction. A byte is held in
// the input register and is parsed on its way into the result registers, so one
// byte is taken in every cycle while the output is not stalled. Synchronous
// reset clears the parse state and the snapshot, which therefore reads all zero.
// A stall on the output holds the result and, once the input register is full,
// drops in_tready; nothing is lost or repeated.
`timescale 1ns / 1ps
`include "csv_three_count_line_parser_macros.svh"

module csv_three_count_line_parser
  import csv3lp_pkg::*;
#(
  parameter int unsigned LINE_BYTES = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // rx_byte[7:0], now_tick[39:8]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // person_count[15:0], half_count[31:16],
                                   // work_count[47:32], commit_tick[79:48],
                                   // bad_line_count[111:80]
  output logic [1:0]   out_tuser   // line_event[1:0]
);

  localparam int unsigned LEN_W = $clog2(LINE_BYTES);

  // Input register stage.
  logic        in_vld_r;
  logic [7:0]  in_byte_r;
  logic [31:0] in_tick_r;

  // Parse state; the snapshot and event registers are also the result register.
  line_st_t         line_r, line_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  snap_t            snap_r, snap_nxt;
  event_t           event_r, event_nxt;
  logic             out_vld_r;

  logic move;

  // Event classes and the counter step, used by the checks at the end.
  logic        bad_evt;
  logic        accept_evt;
  logic [31:0] bad_next;

  // The parsed byte advances whenever the result slot is empty or being drained.
  // The state only changes together with the result, so the result the consumer
  // sees is always the snapshot right after its own byte.
  assign move      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || move;

  csv3lp_parse #(
    .LINE_BYTES (LINE_BYTES),
    .LEN_W      (LEN_W)
  ) u_parse (
    .rx_byte   (in_byte_r),
    .now_tick  (in_tick_r),
    .cur_line  (line_r),
    .cur_len   (len_r),
    .cur_snap  (snap_r),
    .nxt_line  (line_nxt),
    .nxt_len   (len_nxt),
    .nxt_snap  (snap_nxt),
    .nxt_event (event_nxt)
  );

  // Input register: valid is control state, the payload needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata[7:0];
      in_tick_r <= in_tdata[39:8];
    end
  end

  // Parse state, snapshot and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r    <= LINE_CLEAR;
      len_r     <= '0;
      snap_r    <= SNAP_CLEAR;
      event_r   <= EV_NONE;
      out_vld_r <= 1'b0;
    end else begin
      if (move) begin
        line_r  <= line_nxt;
        len_r   <= len_nxt;
        snap_r  <= snap_nxt;
        event_r <= event_nxt;
      end
      if (move) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {snap_r.bad_count, snap_r.tick, snap_r.work, snap_r.half,
                       snap_r.person};
  assign out_tuser  = event_r;

  assign bad_evt    = (event_nxt == EV_REJECT) || (event_nxt == EV_OVERFLOW);
  assign accept_evt = (event_nxt == EV_ACCEPT);
  assign bad_next   = snap_r.bad_count + 32'd1;

  // Nothing in the state may change while no byte is being parsed.
  `CSV3LP_ASSERT_NEXT(a_state_hold, !move, $stable({snap_r, len_r, line_r}), "state moved idle")
  // The collected length never passes the last usable position.
  `CSV3LP_ASSERT_NOW(a_len_bound, 1'b1, len_r <= LEN_W'(LINE_BYTES - 1), "length out of range")
  // A rejected or overlong line bumps the bad-line counter by exactly one.
  `CSV3LP_ASSERT_NEXT(a_bad_step, move && bad_evt, snap_r.bad_count == $past(bad_next), "bad count")
  // An accepted line records the time stamp that came with its terminator.
  `CSV3LP_ASSERT_NEXT(a_tick_commit, move && accept_evt, snap_r.tick == $past(in_tick_r), "tick")

endmodule
